### hw/rtl/pwa_pkg.sv
`timescale 1ns / 1ps
// pwa_pkg: sizes, payload structs and sequencer states for point_window_average.
// No dependencies; imported by hw/rtl/point_window_average.sv.

package pwa_pkg;

    localparam int MAX_WINDOW  = 16;
    localparam int COORD_BITS  = 12;
    localparam int IDX_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W       = COORD_BITS + IDX_W;
    localparam int STEP_W      = $clog2(COORD_BITS);
    localparam int WIN_W       = 5;
    localparam int COUNT_OUT_W = 5;

    localparam logic [WIN_W-1:0] WINDOW_LEN_RESET = WIN_W'(10);

    localparam logic REQ_POINT = 1'b0;
    localparam logic REQ_EMPTY = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
    } pwa_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  avg_x;
        logic [COORD_BITS-1:0]  avg_y;
        logic [COUNT_OUT_W-1:0] point_count;
        logic                   avg_valid;
    } pwa_out_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } pwa_ring_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DROP,
        ST_APPEND,
        ST_SETUP,
        ST_DIV,
        ST_OUT
    } pwa_state_t;

endpackage

### hw/rtl/point_window_average.sv
`timescale 1ns / 1ps
// point_window_average: moving average of the latest detected points, serial divider.
// Depends on hw/rtl/pwa_pkg.sv.
//
// Sequence: ST_READ, ST_DROP, ST_APPEND (points), ST_SETUP, ST_DIV (nonempty window),
// ST_OUT (waits while the output is full); the divide runs one quotient bit per cycle,
// x then y, on one shared subtractor. s_ready is high only while idle.
// Reset (aresetn low, synchronous): window empty, sums zero, window_len back to 10,
// output register empty. Ring contents are not cleared; only written entries are read.

module point_window_average
    import pwa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_valid,
    output logic             s_ready,
    input  pwa_in_t          s_data,

    output logic             m_valid,
    input  logic             m_ready,
    output pwa_out_t         m_data,

    input  logic             cfg_wr_en,
    input  logic [WIN_W-1:0] cfg_wr_data
);

    // Common width for comparing the window register against the ring depth.
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    pwa_state_t            state_reg, state_next;
    logic [WIN_W-1:0]      window_len_reg;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic [IDX_W-1:0]      oldest_reg, oldest_next;
    logic [SUM_W-1:0]      sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]      sum_y_reg, sum_y_next;

    // Latched input transaction
    pwa_in_t               req_reg;

    // Ring memory, registered read at the oldest slot
    pwa_ring_t             ring_mem [MAX_WINDOW];
    pwa_ring_t             rd_reg;
    logic [IDX_W-1:0]      wr_slot;
    logic                  wr_en;

    // Serial divider: remainder and dividend/quotient shift register
    logic [IDX_W-1:0]      rem_reg, rem_next;
    logic [COORD_BITS-1:0] dq_reg, dq_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  div_sel_reg, div_sel_next;   // 0: x pass, 1: y pass
    logic [COORD_BITS-1:0] avg_x_reg, avg_x_next;
    logic [COORD_BITS-1:0] avg_y_reg, avg_y_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    pwa_out_t              m_data_reg, m_data_next;
    logic                  m_load;

    // Datapath helpers
    logic [CNT_W-1:0]      eff_win;
    logic [CMP_W-1:0]      win_ext;
    logic                  drop_en;
    logic [IDX_W:0]        trial;
    logic [IDX_W:0]        cnt_ext;
    logic                  trial_ge;
    logic [IDX_W:0]        trial_diff;
    logic [COORD_BITS-1:0] dq_shift;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] v);
        if (v >= (IDX_W+1)'(MAX_WINDOW)) begin
            return IDX_W'(v - (IDX_W+1)'(MAX_WINDOW));
        end else begin
            return IDX_W'(v);
        end
    endfunction

    // ---------------------------------------------------------------------
    // Effective window: zero acts as one, large values clamp to ring depth
    // ---------------------------------------------------------------------
    always_comb begin
        win_ext = CMP_W'(window_len_reg);
        if (window_len_reg == '0) begin
            eff_win = CNT_W'(1);
        end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
            eff_win = CNT_W'(MAX_WINDOW);
        end else begin
            eff_win = CNT_W'(win_ext);
        end
    end

    // New point drops the oldest when the window is full; empty frame drops if any held.
    assign drop_en = (req_reg.req_type == REQ_POINT) ? (held_reg >= eff_win)
                                                     : (held_reg != '0);

    // One restoring-division step; the quotient fits COORD_BITS, so the top
    // IDX_W dividend bits seed the remainder directly.
    assign trial      = {rem_reg, dq_reg[COORD_BITS-1]};
    assign cnt_ext    = (IDX_W+1)'(held_reg);
    assign trial_ge   = (trial >= cnt_ext);
    assign trial_diff = trial - cnt_ext;
    assign dq_shift   = {dq_reg[COORD_BITS-2:0], trial_ge};

    assign wr_slot = wrap_idx((IDX_W+1)'(oldest_reg) + (IDX_W+1)'(held_reg));
    assign wr_en   = (state_reg == ST_APPEND);
    assign m_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        held_next    = held_reg;
        oldest_next  = oldest_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        step_next    = step_reg;
        div_sel_next = div_sel_reg;
        avg_x_next   = avg_x_reg;
        avg_y_next   = avg_y_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end

            ST_READ: begin
                state_next = ST_DROP;
            end

            ST_DROP: begin
                if (drop_en) begin
                    sum_x_next  = sum_x_reg - SUM_W'(rd_reg.x);
                    sum_y_next  = sum_y_reg - SUM_W'(rd_reg.y);
                    oldest_next = wrap_idx((IDX_W+1)'(oldest_reg) + (IDX_W+1)'(1));
                    held_next   = held_reg - CNT_W'(1);
                end
                state_next = (req_reg.req_type == REQ_POINT) ? ST_APPEND : ST_SETUP;
            end

            ST_APPEND: begin
                sum_x_next = sum_x_reg + SUM_W'(req_reg.point_x);
                sum_y_next = sum_y_reg + SUM_W'(req_reg.point_y);
                held_next  = held_reg + CNT_W'(1);
                state_next = ST_SETUP;
            end

            ST_SETUP: begin
                if (held_reg == '0) begin
                    avg_x_next = '0;
                    avg_y_next = '0;
                    state_next = ST_OUT;
                end else begin
                    rem_next     = sum_x_reg[SUM_W-1:COORD_BITS];
                    dq_next      = sum_x_reg[COORD_BITS-1:0];
                    step_next    = '0;
                    div_sel_next = 1'b0;
                    state_next   = ST_DIV;
                end
            end

            ST_DIV: begin
                rem_next  = trial_ge ? IDX_W'(trial_diff) : IDX_W'(trial);
                dq_next   = dq_shift;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(COORD_BITS - 1)) begin
                    if (!div_sel_reg) begin
                        avg_x_next   = dq_shift;
                        rem_next     = sum_y_reg[SUM_W-1:COORD_BITS];
                        dq_next      = sum_y_reg[COORD_BITS-1:0];
                        step_next    = '0;
                        div_sel_next = 1'b1;
                    end else begin
                        avg_y_next = dq_shift;
                        state_next = ST_OUT;
                    end
                end
            end

            ST_OUT: begin
                if (m_load) begin
                    m_valid_next            = 1'b1;
                    m_data_next.avg_x       = avg_x_reg;
                    m_data_next.avg_y       = avg_y_reg;
                    m_data_next.point_count = COUNT_OUT_W'(held_reg);
                    m_data_next.avg_valid   = (held_reg != '0);
                    state_next              = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            window_len_reg <= WINDOW_LEN_RESET;
            held_reg       <= '0;
            oldest_reg     <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            oldest_reg  <= oldest_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                window_len_reg <= cfg_wr_data;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers and divider (no reset)
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        step_reg    <= step_next;
        div_sel_reg <= div_sel_next;
        avg_x_reg   <= avg_x_next;
        avg_y_reg   <= avg_y_next;
        m_data_reg  <= m_data_next;
    end

    // ---------------------------------------------------------------------
    // Ring memory
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_slot] <= '{x: req_reg.point_x, y: req_reg.point_y};
        end
        rd_reg <= ring_mem[oldest_reg];
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
